// ===== rtl/dpwb_pkg.sv =====
// ----------------------------------------------------------------------------
// Dual PLL program word builder package
// Shared types, constants and word packing functions.
// ----------------------------------------------------------------------------
package dpwb_pkg;

   localparam int FreqWidth   = 22;
   localparam int DivWidth    = 16;
   localparam int WordWidth   = 22;
   localparam int RefWidth    = 14;
   localparam int ModeWidth   = 3;
   localparam int CountWidth  = 18;
   localparam int AWidth      = 6;
   localparam int BWidth      = 11;
   localparam int Words       = 3;
   localparam int CntWidth    = $clog2(Words + 1);
   localparam int AddrWidth   = 3;
   localparam int DataWidth   = 32;

   localparam int MultWidth   = 23;
   localparam int Div25Shift  = 27;
   localparam int ProdWidth   = FreqWidth + MultWidth;
   localparam logic [MultWidth-1:0] Div25Mult = 23'd5368710;

   localparam logic [FreqWidth-1:0] P64FromKhz = 22'd1800000;
   localparam logic [RefWidth-1:0]  RefCountReset = 14'd160;
   localparam logic [ModeWidth-1:0] ModeBitsReset = 3'd1;

   localparam logic [1:0] AddrRf2R  = 2'd0;
   localparam logic [1:0] AddrRf2Ab = 2'd1;
   localparam logic [1:0] AddrRf1R  = 2'd2;
   localparam logic [1:0] AddrRf1Ab = 2'd3;

   localparam logic CmdSetFreq = 1'b0;
   localparam logic CmdSetDiv  = 1'b1;

   localparam logic RegRefCount = 1'b0;
   localparam logic RegModeBits = 1'b1;

   typedef logic [WordWidth-1:0] word_type;
   typedef word_type [Words-1:0] word_set_type;

   typedef struct packed {
      logic                 command;
      logic                 channel;
      logic [FreqWidth-1:0] freq_khz;
      logic [DivWidth-1:0]  divider;
   } req_type;

   typedef struct packed {
      logic [WordWidth-1:0] word;
      logic                 last;
   } rsp_type;

   typedef struct packed {
      logic [RefWidth-1:0]  ref_count;
      logic [ModeWidth-1:0] mode_bits;
   } cfg_type;

   function automatic word_type make_r(input logic [1:0] addr, input logic b21,
                                       input logic b20, input cfg_type cfg);
      return {b21, b20, cfg.mode_bits, 1'b0, cfg.ref_count, addr};
   endfunction

   function automatic word_type make_ab(input logic [1:0] addr, input logic [AWidth-1:0] a,
                                        input logic [BWidth-1:0] b, input logic p32);
      return {1'b0, p32, b, 1'b0, a, addr};
   endfunction

endpackage

// ===== rtl/dual_pll_program_word_builder_unit.sv =====
// ----------------------------------------------------------------------------
// Dual PLL program word builder
// Turns each command into three 22-bit synthesizer programming words.
// ----------------------------------------------------------------------------
// Each item on the req_ channel is a command: a frequency in kHz or a direct
// divider for one of the two synthesizers. It yields three items on the rsp_
// channel: two reference words and then the A/B counter word, the last one
// marked by rsp_data.last. The csr_ port sets the reference count and the mode
// bits and should be written only while no command is in flight.
// An accepted command sits in an input register; its three words are built from
// it and loaded into the output stage once that stage is free, and the output
// stage shows the first word. The output stage sends one word per cycle while
// the receiver does not stall. The next command is taken into the input
// register while the current words are still being sent.
// When the receiver stalls, the shown word holds and req_stall rises once the
// input register is full. Reset empties both stages and restores the
// reference count to 160 and the mode bits to 1.
// ----------------------------------------------------------------------------
module dual_pll_program_word_builder_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  dpwb_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output dpwb_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dpwb_pkg::AddrWidth-1:0]  csr_paddr,
   input  logic [dpwb_pkg::DataWidth-1:0]  csr_pwdata,
   output logic [dpwb_pkg::DataWidth-1:0]  csr_prdata,
   output logic                            csr_pready
);

   dpwb_pkg::req_type      req_ff, req_in;
   logic                   held_ff, held_in;
   dpwb_pkg::cfg_type      cfg;
   dpwb_pkg::word_set_type words;
   logic                   load_ready;
   logic                   req_fire;

   assign req_stall = held_ff && !load_ready;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      req_in  = req_ff;
      held_in = held_ff;
      if (req_fire) begin
         req_in  = req_data;
         held_in = 1'b1;
      end else if (load_ready) begin
         held_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
      req_ff <= req_in;
   end

   dpwb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   dpwb_calc u_calc (
      .req   (req_ff),
      .cfg   (cfg),
      .words (words)
   );

   dpwb_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load_valid (held_ff),
      .load_words (words),
      .load_ready (load_ready),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

// ===== rtl/dpwb_csr.sv =====
// ----------------------------------------------------------------------------
// Dual PLL program word builder registers
// APB-style register file holding the reference count and mode bits.
// ----------------------------------------------------------------------------
module dpwb_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dpwb_pkg::AddrWidth-1:0]  csr_paddr,
   input  logic [dpwb_pkg::DataWidth-1:0]  csr_pwdata,
   output logic [dpwb_pkg::DataWidth-1:0]  csr_prdata,
   output logic                            csr_pready,
   output dpwb_pkg::cfg_type               cfg
);

   logic [dpwb_pkg::RefWidth-1:0]  ref_count_ff, ref_count_in;
   logic [dpwb_pkg::ModeWidth-1:0] mode_bits_ff, mode_bits_in;
   logic                           wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      ref_count_in = ref_count_ff;
      mode_bits_in = mode_bits_ff;
      if (wr_en) begin
         if (csr_paddr[2] == dpwb_pkg::RegRefCount) begin
            ref_count_in = csr_pwdata[dpwb_pkg::RefWidth-1:0];
         end else begin
            mode_bits_in = csr_pwdata[dpwb_pkg::ModeWidth-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_count_ff <= dpwb_pkg::RefCountReset;
         mode_bits_ff <= dpwb_pkg::ModeBitsReset;
      end else begin
         ref_count_ff <= ref_count_in;
         mode_bits_ff <= mode_bits_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == dpwb_pkg::RegRefCount) begin
         csr_prdata = dpwb_pkg::DataWidth'(ref_count_ff);
      end else begin
         csr_prdata = dpwb_pkg::DataWidth'(mode_bits_ff);
      end
   end

   assign cfg.ref_count = ref_count_ff;
   assign cfg.mode_bits = mode_bits_ff;

endmodule

// ===== rtl/dpwb_calc.sv =====
// ----------------------------------------------------------------------------
// Dual PLL program word calculator
// Builds the two reference words and the A/B counter word of one command.
// ----------------------------------------------------------------------------
module dpwb_calc (
   input  dpwb_pkg::req_type      req,
   input  dpwb_pkg::cfg_type      cfg,
   output dpwb_pkg::word_set_type words
);

   logic [dpwb_pkg::ProdWidth-1:0]  prod;
   logic [dpwb_pkg::CountWidth-1:0] count;
   logic                            p64;
   logic [dpwb_pkg::AWidth-1:0]     a_val;
   logic [dpwb_pkg::BWidth-1:0]     b_val;
   logic [1:0]                      addr0, addr1, addr_ab;
   logic                            b21_0, b20_0, b20_1;

   // Division by the 25 kHz step as a reciprocal multiply, exact for 22-bit inputs.
   assign prod = dpwb_pkg::ProdWidth'(req.freq_khz) * dpwb_pkg::ProdWidth'(dpwb_pkg::Div25Mult);

   always_comb begin
      if (req.command == dpwb_pkg::CmdSetFreq) begin
         count = prod[dpwb_pkg::ProdWidth-1:dpwb_pkg::Div25Shift];
         p64   = (req.freq_khz >= dpwb_pkg::P64FromKhz);
      end else begin
         count = dpwb_pkg::CountWidth'(req.divider);
         p64   = 1'b0;
      end
      if (p64) begin
         a_val = count[5:0];
         b_val = count[16:6];
      end else begin
         a_val = {1'b0, count[4:0]};
         b_val = count[15:5];
      end
   end

   assign addr0   = req.channel ? dpwb_pkg::AddrRf2R  : dpwb_pkg::AddrRf1R;
   assign addr1   = req.channel ? dpwb_pkg::AddrRf1R  : dpwb_pkg::AddrRf2R;
   assign addr_ab = req.channel ? dpwb_pkg::AddrRf2Ab : dpwb_pkg::AddrRf1Ab;

   assign b21_0 = (req.command == dpwb_pkg::CmdSetDiv) || !req.channel;
   assign b20_0 = (req.command == dpwb_pkg::CmdSetDiv) && req.channel;
   assign b20_1 = (req.command == dpwb_pkg::CmdSetDiv) && !req.channel;

   assign words[0] = dpwb_pkg::make_r(addr0, b21_0, b20_0, cfg);
   assign words[1] = dpwb_pkg::make_r(addr1, 1'b0, b20_1, cfg);
   assign words[2] = dpwb_pkg::make_ab(addr_ab, a_val, b_val, !p64);

endmodule

// ===== rtl/dpwb_out.sv =====
// ----------------------------------------------------------------------------
// Dual PLL program word output stage
// Holds the three words of one command and hands them out in order.
// ----------------------------------------------------------------------------
module dpwb_out (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load_valid,
   input  dpwb_pkg::word_set_type load_words,
   output logic                   load_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output dpwb_pkg::rsp_type      rsp_data
);

   dpwb_pkg::word_set_type        words_ff, words_in;
   logic [dpwb_pkg::CntWidth-1:0] cnt_ff, cnt_in;
   logic                          valid_ff, valid_in;
   logic                          fire, is_last;

   assign is_last    = (cnt_ff == dpwb_pkg::CntWidth'(1));
   assign fire       = valid_ff && !rsp_stall;
   assign load_ready = !valid_ff || (fire && is_last);

   always_comb begin
      words_in = words_ff;
      cnt_in   = cnt_ff;
      valid_in = valid_ff;
      if (load_valid && load_ready) begin
         words_in = load_words;
         cnt_in   = dpwb_pkg::CntWidth'(dpwb_pkg::Words);
         valid_in = 1'b1;
      end else if (fire) begin
         if (is_last) begin
            valid_in = 1'b0;
         end else begin
            for (int i = 0; i < dpwb_pkg::Words - 1; i++) begin
               words_in[i] = words_ff[i+1];
            end
            cnt_in = cnt_ff - dpwb_pkg::CntWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         cnt_ff   <= cnt_in;
      end
      words_ff <= words_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_data.word = words_ff[0];
   assign rsp_data.last = is_last;

endmodule

// ===== rtl/dpwb_checker.sv =====
// ----------------------------------------------------------------------------
// Dual PLL program word builder checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module dpwb_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input dpwb_pkg::rsp_type rsp_data
);

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result item changed or was dropped.");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Result item shown right after reset.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("Gap inside the words of one command.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last == rsp_data.word[0]))
      else $error("Last mark does not match the word address.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> !rsp_data.word[21] && !rsp_data.word[8])
      else $error("Counter word has a reserved bit set.");

endmodule

bind dual_pll_program_word_builder_unit dpwb_checker u_dpwb_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
